/* hw/rtl/fbpa_pkg.sv */
// Shared types and constants for the fixed block pool allocator.
// Used by fbpa_cell, fbpa_stack and fixed_block_pool_allocator_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fbpa_pkg;

   // pool size limit, default for the top level parameter
   localparam int NUM_BLOCKS_DEFAULT = 64;

   // port field widths
   localparam int SIZE_W     = 16;
   localparam int INDEX_W    = 6;
   localparam int ADDR_W     = 32;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 7;
   localparam int BSIZE_W    = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // block size limits
   localparam logic [BSIZE_W-1:0] BSIZE_MAX = 13'd4096;
   localparam logic [BSIZE_W-1:0] BSIZE_MIN = 13'd1;

   // register reset values
   localparam logic [BSIZE_W-1:0] BSIZE_RESET = 13'd64;
   localparam logic [COUNT_W-1:0] BCOUNT_RESET = 7'd64;
   localparam logic [ADDR_W-1:0]  BASE_RESET = 32'd0;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = 2'd2;

   // request operations
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FALLBACK = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FREED    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd4;

   // control for the cell chain: load rebuilds, push shifts toward the tail,
   // pop shifts toward the head
   typedef struct packed {
      logic load;
      logic push;
      logic pop;
   } stack_ctrl_type;

endpackage

`default_nettype wire

/* hw/rtl/fbpa_cell.sv */
// One entry of the free index stack; takes from either neighbor or loads.
// Depends on fbpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbpa_cell #(
   parameter int IDX_W = 6
) (
   input  wire                         clock,
   input  wire fbpa_pkg::stack_ctrl_type ctrl,
   input  wire  [IDX_W-1:0]            load_value,
   input  wire  [IDX_W-1:0]            from_head,
   input  wire  [IDX_W-1:0]            from_tail,
   output logic [IDX_W-1:0]            value
);

   logic [IDX_W-1:0] value_ff;
   logic [IDX_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctrl.load) begin
         value_in = load_value;
      end else if (ctrl.push) begin
         value_in = from_head;
      end else if (ctrl.pop) begin
         value_in = from_tail;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

/* hw/rtl/fbpa_stack.sv */
// Free index stack built as a chain of cells; cell 0 is the top of stack.
// Depends on fbpa_pkg and fbpa_cell.
`timescale 1ns / 1ps
`default_nettype none

module fbpa_stack #(
   parameter int NUM_BLOCKS = fbpa_pkg::NUM_BLOCKS_DEFAULT,
   parameter int IDX_W      = $clog2(NUM_BLOCKS),
   parameter int CNT_W      = $clog2(NUM_BLOCKS + 1)
) (
   input  wire                         clock,
   input  wire fbpa_pkg::stack_ctrl_type ctrl,
   input  wire  [CNT_W-1:0]            count,
   input  wire  [IDX_W-1:0]            push_value,
   output logic [IDX_W-1:0]            top_value
);

   logic [IDX_W-1:0] cell_value [NUM_BLOCKS];

   for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
      logic [IDX_W-1:0] load_value;
      logic [IDX_W-1:0] from_head;
      logic [IDX_W-1:0] from_tail;

      // ascending fill: the highest index sits on top
      assign load_value = IDX_W'(32'(count) - 32'(k) - 32'd1);

      if (k == 0) begin : g_head
         assign from_head = push_value;
      end else begin : g_mid
         assign from_head = cell_value[k-1];
      end

      if (k == NUM_BLOCKS - 1) begin : g_tail
         assign from_tail = '0;
      end else begin : g_body
         assign from_tail = cell_value[k+1];
      end

      fbpa_cell #(
         .IDX_W (IDX_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .load_value (load_value),
         .from_head  (from_head),
         .from_tail  (from_tail),
         .value      (cell_value[k])
      );
   end

   assign top_value = cell_value[0];

endmodule

`default_nettype wire

/* hw/rtl/fixed_block_pool_allocator_top.sv */
// Fixed block pool allocator: free index stack, allocated marks, result register.
// Depends on fbpa_pkg and fbpa_stack.
//
//  channel | ports                                             | direction
//  --------+---------------------------------------------------+----------
//  req     | req_valid/ready, func, request_size, block_index  | in
//  rsp     | rsp_valid/ready, status, granted_index,           | out
//          | block_address, free_count, allocated_count        |
//  csr     | csr_valid/ready, csr_index, csr_data              | in
//
// A push or pop shifts the cell chain in the same cycle the item is accepted,
// and the result is registered for the next cycle.
// Sustained rate is one item per cycle while rsp_ready stays high.
// After reset and after every write to a listed register the chain reloads,
// during which req_ready is low; csr writes are always taken.
// A result waiting with rsp_ready low holds and blocks new items.
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_pool_allocator_top #(
   parameter int NUM_BLOCKS = fbpa_pkg::NUM_BLOCKS_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,

   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire                                  req_func,
   input  wire  [fbpa_pkg::SIZE_W-1:0]          req_request_size,
   input  wire  [fbpa_pkg::INDEX_W-1:0]         req_block_index,

   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [fbpa_pkg::STATUS_W-1:0]        rsp_status,
   output logic [fbpa_pkg::INDEX_W-1:0]         rsp_granted_index,
   output logic [fbpa_pkg::ADDR_W-1:0]          rsp_block_address,
   output logic [fbpa_pkg::COUNT_W-1:0]         rsp_free_count,
   output logic [fbpa_pkg::COUNT_W-1:0]         rsp_allocated_count,

   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [fbpa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [fbpa_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int IDX_W  = $clog2(NUM_BLOCKS);
   localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
   localparam int PROD_W = IDX_W + fbpa_pkg::BSIZE_W;

   // configuration registers
   logic [fbpa_pkg::BSIZE_W-1:0] bsize_ff, bsize_in;
   logic [fbpa_pkg::COUNT_W-1:0] bcount_ff, bcount_in;
   logic [fbpa_pkg::ADDR_W-1:0]  base_ff, base_in;
   logic                         rebuild_ff, rebuild_in;

   // pool state
   logic [CNT_W-1:0]      depth_ff, depth_in;
   logic [CNT_W-1:0]      total_ff, total_in;
   logic [NUM_BLOCKS-1:0] mark_ff, mark_in;

   // result register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [fbpa_pkg::STATUS_W-1:0]     status_ff, status_in;
   logic [fbpa_pkg::INDEX_W-1:0]      gidx_ff, gidx_in;
   logic [fbpa_pkg::ADDR_W-1:0]       addr_ff, addr_in;
   logic [fbpa_pkg::COUNT_W-1:0]      free_cnt_ff, free_cnt_in;
   logic [fbpa_pkg::COUNT_W-1:0]      alloc_cnt_ff, alloc_cnt_in;

   logic [fbpa_pkg::BSIZE_W-1:0] size_eff;
   logic [CNT_W-1:0]             count_eff;
   logic                         csr_write;
   logic                         accept;
   logic                         grant;
   logic                         free_ok;
   logic                         idx_in_range;
   logic [IDX_W-1:0]             free_idx;
   logic [IDX_W-1:0]             top_idx;
   logic [PROD_W-1:0]            offset;
   fbpa_pkg::stack_ctrl_type     ctrl;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      bsize_in   = bsize_ff;
      bcount_in  = bcount_ff;
      base_in    = base_ff;
      rebuild_in = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            fbpa_pkg::CSR_BLOCK_SIZE: begin
               bsize_in   = csr_data[fbpa_pkg::BSIZE_W-1:0];
               rebuild_in = 1'b1;
            end
            fbpa_pkg::CSR_BLOCK_COUNT: begin
               bcount_in  = csr_data[fbpa_pkg::COUNT_W-1:0];
               rebuild_in = 1'b1;
            end
            fbpa_pkg::CSR_BASE_ADDRESS: begin
               base_in    = csr_data[fbpa_pkg::ADDR_W-1:0];
               rebuild_in = 1'b1;
            end
            default: begin
               rebuild_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bsize_ff   <= fbpa_pkg::BSIZE_RESET;
         bcount_ff  <= fbpa_pkg::BCOUNT_RESET;
         base_ff    <= fbpa_pkg::BASE_RESET;
         rebuild_ff <= 1'b1;
      end else begin
         bsize_ff   <= bsize_in;
         bcount_ff  <= bcount_in;
         base_ff    <= base_in;
         rebuild_ff <= rebuild_in;
      end
   end

   // clamp register values to their legal ranges
   always_comb begin
      if (bsize_ff == '0) begin
         size_eff = fbpa_pkg::BSIZE_MIN;
      end else if (bsize_ff > fbpa_pkg::BSIZE_MAX) begin
         size_eff = fbpa_pkg::BSIZE_MAX;
      end else begin
         size_eff = bsize_ff;
      end

      if (bcount_ff == '0) begin
         count_eff = CNT_W'(1);
      end else if (32'(bcount_ff) > 32'(NUM_BLOCKS)) begin
         count_eff = CNT_W'(NUM_BLOCKS);
      end else begin
         count_eff = CNT_W'(bcount_ff);
      end
   end

   // ---------------- request decode ----------------
   assign req_ready = !rebuild_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign free_idx     = IDX_W'(req_block_index);
   assign idx_in_range = (32'(req_block_index) < 32'(NUM_BLOCKS))
                      && (32'(req_block_index) < 32'(count_eff));

   assign grant = (req_func == fbpa_pkg::FUNC_ALLOC)
               && (req_request_size != '0)
               && (req_request_size <= fbpa_pkg::SIZE_W'(size_eff))
               && (depth_ff != '0);

   assign free_ok = (req_func == fbpa_pkg::FUNC_FREE)
                 && idx_in_range
                 && mark_ff[free_idx]
                 && (32'(depth_ff) < 32'(NUM_BLOCKS));

   // ---------------- free index stack ----------------
   assign ctrl.load = rebuild_ff;
   assign ctrl.push = accept && free_ok;
   assign ctrl.pop  = accept && grant;

   fbpa_stack #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
   ) u_stack (
      .clock      (clock),
      .ctrl       (ctrl),
      .count      (count_eff),
      .push_value (free_idx),
      .top_value  (top_idx)
   );

   // ---------------- pool counters and marks ----------------
   always_comb begin
      depth_in = depth_ff;
      total_in = total_ff;
      mark_in  = mark_ff;
      if (rebuild_ff) begin
         depth_in = count_eff;
         total_in = '0;
         mark_in  = '0;
      end else if (ctrl.pop) begin
         depth_in         = depth_ff - CNT_W'(1);
         total_in         = total_ff + CNT_W'(1);
         mark_in[top_idx] = 1'b1;
      end else if (ctrl.push) begin
         depth_in          = depth_ff + CNT_W'(1);
         total_in          = (total_ff != '0) ? total_ff - CNT_W'(1) : total_ff;
         mark_in[free_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         total_ff <= '0;
         mark_ff  <= '0;
      end else begin
         depth_ff <= depth_in;
         total_ff <= total_in;
         mark_ff  <= mark_in;
      end
   end

   // ---------------- result ----------------
   assign offset = PROD_W'(top_idx) * PROD_W'(size_eff);

   always_comb begin
      gidx_in = '0;
      addr_in = '0;
      if (req_func == fbpa_pkg::FUNC_ALLOC) begin
         if (req_request_size == '0) begin
            status_in = fbpa_pkg::ST_ZERO;
         end else if (grant) begin
            status_in = fbpa_pkg::ST_GRANTED;
            gidx_in   = fbpa_pkg::INDEX_W'(top_idx);
            addr_in   = base_ff + fbpa_pkg::ADDR_W'(offset);
         end else begin
            status_in = fbpa_pkg::ST_FALLBACK;
         end
      end else begin
         status_in = free_ok ? fbpa_pkg::ST_FREED : fbpa_pkg::ST_IGNORED;
      end
      free_cnt_in  = fbpa_pkg::COUNT_W'(depth_in);
      alloc_cnt_in = fbpa_pkg::COUNT_W'(total_in);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         gidx_ff      <= gidx_in;
         addr_ff      <= addr_in;
         free_cnt_ff  <= free_cnt_in;
         alloc_cnt_ff <= alloc_cnt_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_granted_index   = gidx_ff;
   assign rsp_block_address   = addr_ff;
   assign rsp_free_count      = free_cnt_ff;
   assign rsp_allocated_count = alloc_cnt_ff;

   // ---------------- assertions ----------------
   a_blocks_conserved: assert property (@(posedge clock) disable iff (reset)
      !rebuild_ff |-> ((CNT_W+1)'(depth_ff) + (CNT_W+1)'(total_ff))
                      == (CNT_W+1)'(count_eff))
      else $error("free plus allocated blocks differ from block count");

   a_marks_match_total: assert property (@(posedge clock) disable iff (reset)
      !rebuild_ff |-> (32'($countones(mark_ff)) == 32'(total_ff)))
      else $error("allocated marks disagree with allocated count");

   a_grant_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff != fbpa_pkg::ST_GRANTED))
         |-> ((gidx_ff == '0) && (addr_ff == '0)))
      else $error("index or address set on a result that is not a grant");

   a_no_take_on_rebuild: assert property (@(posedge clock) disable iff (reset)
      $past(csr_write && ((csr_index == fbpa_pkg::CSR_BLOCK_SIZE)
                       || (csr_index == fbpa_pkg::CSR_BLOCK_COUNT)
                       || (csr_index == fbpa_pkg::CSR_BASE_ADDRESS))) |-> !accept)
      else $error("item accepted while the pool reloads");

endmodule

`default_nettype wire
